FILE: design/cfrc_pkg.sv
// ----------------------------------------------------------------------------
// cfrc_pkg: shared types and constants of the frame reassembly checker
// Status codes, header and result bundles, register indexes and defaults.
// ----------------------------------------------------------------------------
package cfrc_pkg;

    // Default configuration of the image store and payload limit.
    localparam int unsigned IMAGE_BYTES_DEF = 256 * 1024;
    localparam int unsigned MAX_PAYLOAD_DEF = 60 * 1024;

    // Header layout constants.
    localparam logic [15:0] HEADER_BYTES  = 16'd16;
    localparam logic [15:0] VERSION_BYTES = 16'd4;
    localparam int unsigned LAST_BIT      = 16;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [15:0] VERSION_RESET = 16'h5503;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_VERSION = 2'd0,
        CFG_FRAME_CHECK      = 2'd1,
        CFG_OFFSET_CHECK     = 2'd2
    } cfg_index_t;

    // Per-request status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_SHORT   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_FRAME   = 3'd5,
        ST_OFFSET  = 3'd6,
        ST_BEYOND  = 3'd7
    } status_t;

    // One decoded datagram header.
    typedef struct packed {
        logic [15:0] packet_size;
        logic [31:0] version_word;
        logic [31:0] frame_number;
        logic [31:0] chunk_offset;
        logic [31:0] chunk_length;
    } header_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] expected_version;
        logic        frame_check_enable;
        logic        offset_check_enable;
    } cfg_t;

    // Expected position in the frame stream.
    typedef struct packed {
        logic [31:0] next_frame;
        logic [31:0] next_offset;
    } track_t;

    // Result of checking one header.
    typedef struct packed {
        status_t     status;
        logic        write_valid;
        logic [18:0] write_offset;
        logic [15:0] write_length;
        logic        frame_done;
        logic [18:0] frame_bytes;
        logic        rejected;
    } result_t;

endpackage

FILE: design/cfrc_in_reg.sv
// ----------------------------------------------------------------------------
// cfrc_in_reg: input register of the frame reassembly checker
// Captures one header request and holds it until the check stage takes it.
// ----------------------------------------------------------------------------
module cfrc_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cfrc_pkg::header_t hdr_in,
    input  logic             take,
    output logic             hdr_valid,
    output cfrc_pkg::header_t hdr_out
);
    import cfrc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    accept;
    header_t hdr_reg;

    // The register is free when empty or when its request moves on this cycle.
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_in;
        end
    end

    assign hdr_valid = valid_reg;
    assign hdr_out   = hdr_reg;

endmodule

FILE: design/cfrc_eval.sv
// ----------------------------------------------------------------------------
// cfrc_eval: header check logic of the frame reassembly checker
// Runs the size, version, length, frame, offset and image limit checks on one header and
// forms the write window, frame-done flag and next expected position.
// ----------------------------------------------------------------------------
module cfrc_eval #(
    parameter int unsigned IMAGE_BYTES = cfrc_pkg::IMAGE_BYTES_DEF,
    parameter int unsigned MAX_PAYLOAD = cfrc_pkg::MAX_PAYLOAD_DEF
) (
    input  cfrc_pkg::header_t hdr,
    input  cfrc_pkg::cfg_t    cfg,
    input  cfrc_pkg::track_t  track,
    output cfrc_pkg::track_t  track_next,
    output cfrc_pkg::result_t result
);
    import cfrc_pkg::*;

    localparam logic [32:0] IMAGE_LIMIT   = 33'(IMAGE_BYTES);
    localparam logic [15:0] PAYLOAD_LIMIT = 16'(MAX_PAYLOAD);

    logic        last;
    logic [15:0] payload;
    logic        length_bad;
    logic [32:0] end_sum;
    logic        beyond;

    // Operands of the length and window checks.
    assign last       = hdr.version_word[LAST_BIT];
    assign payload    = hdr.packet_size - HEADER_BYTES;
    assign length_bad = (hdr.packet_size < HEADER_BYTES) || (payload > PAYLOAD_LIMIT)
                        || (hdr.chunk_length != {16'd0, payload});
    assign end_sum    = {1'b0, hdr.chunk_offset} + {1'b0, hdr.chunk_length};
    assign beyond     = end_sum > IMAGE_LIMIT;

    // Checks in priority order, then the tracking update.
    always_comb
    begin
        track_next          = track;
        result.status       = ST_OK;
        result.write_valid  = 1'b0;
        result.write_offset = '0;
        result.write_length = '0;
        result.frame_done   = 1'b0;
        result.frame_bytes  = '0;
        if (hdr.packet_size < VERSION_BYTES)
        begin
            result.status = ST_SHORT;
        end
        else if (hdr.version_word[15:0] != cfg.expected_version)
        begin
            result.status = ST_VERSION;
        end
        else if (hdr.packet_size == VERSION_BYTES)
        begin
            result.status = ST_HEADER;
        end
        else if (length_bad)
        begin
            result.status = ST_LENGTH;
        end
        else if (cfg.frame_check_enable && (track.next_frame < hdr.frame_number))
        begin
            result.status          = ST_FRAME;
            track_next.next_frame  = hdr.frame_number + 32'd1;
            track_next.next_offset = '0;
        end
        else if (cfg.offset_check_enable && (track.next_offset != hdr.chunk_offset))
        begin
            result.status          = ST_OFFSET;
            track_next.next_frame  = hdr.frame_number + 32'd1;
            track_next.next_offset = '0;
        end
        else
        begin
            if (last)
            begin
                track_next.next_frame  = track.next_frame + 32'd1;
                track_next.next_offset = '0;
            end
            else
            begin
                track_next.next_offset = track.next_offset + hdr.chunk_length;
            end
            if (beyond)
            begin
                result.status = ST_BEYOND;
            end
            else
            begin
                if (hdr.chunk_length != 32'd0)
                begin
                    result.write_valid  = 1'b1;
                    result.write_offset = hdr.chunk_offset[18:0];
                    result.write_length = hdr.chunk_length[15:0];
                end
                if (last)
                begin
                    result.frame_done  = 1'b1;
                    result.frame_bytes = end_sum[18:0];
                end
            end
        end

        // Statuses from too short through offset count as rejected.
        result.rejected = (result.status != ST_OK) && (result.status != ST_HEADER)
                          && (result.status != ST_BEYOND);
    end

endmodule

FILE: design/chunked_frame_reassembly_checker.sv
// ----------------------------------------------------------------------------
// chunked_frame_reassembly_checker: checks chunk headers of a framed stream
// Validates each datagram header, tracks the expected frame and offset, and
// reports a status, an image store write window and frame completion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall carry one decoded header per request
//   (packet_size, version_word, frame_number, chunk_offset, chunk_length).
//   Output channel: out_valid/out_stall carry one result per header, in
//   order: status, write window, frame-done flag with frame size, and the
//   running error and packet counts including this header.
//   Configuration: cfg_write, cfg_index and cfg_data write the expected
//   version and the frame and offset check enables; write only while idle.
//   Path: an accepted header waits in the input register, and its result is
//   captured in the result register, which drives the outputs.
//   Throughput: one header per cycle while out_stall is low; the check
//   logic sits between the input register and the result register, and the
//   expected frame and offset are updated as each result is registered.
//   Stall: while out_stall holds a result, the input register still takes
//   one more header, and in_stall rises once that register is full.
//   Reset: clears the expected frame and offset, both counts and the output
//   valid flag, and restores the configuration defaults.
// ----------------------------------------------------------------------------
module chunked_frame_reassembly_checker #(
    parameter int unsigned IMAGE_BYTES = cfrc_pkg::IMAGE_BYTES_DEF,
    parameter int unsigned MAX_PAYLOAD = cfrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [cfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     packet_size,
    input  logic [31:0]                     version_word,
    input  logic [31:0]                     frame_number,
    input  logic [31:0]                     chunk_offset,
    input  logic [31:0]                     chunk_length,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic                            write_valid,
    output logic [18:0]                     write_offset,
    output logic [15:0]                     write_length,
    output logic                            frame_done,
    output logic [18:0]                     frame_bytes,
    output logic [31:0]                     error_total,
    output logic [31:0]                     packet_total
);
    import cfrc_pkg::*;

    header_t hdr_in;
    header_t hdr;
    logic    hdr_valid;
    logic    take;

    cfg_t    cfg_reg;
    track_t  track_reg;
    track_t  track_next;
    result_t eval_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic [31:0] rejected_count_reg;
    logic [31:0] rejected_count_next;
    logic [31:0] received_count_reg;
    logic [31:0] received_count_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version    <= VERSION_RESET;
            cfg_reg.frame_check_enable  <= 1'b1;
            cfg_reg.offset_check_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_VERSION: cfg_reg.expected_version    <= cfg_data;
                CFG_FRAME_CHECK:      cfg_reg.frame_check_enable  <= cfg_data[0];
                CFG_OFFSET_CHECK:     cfg_reg.offset_check_enable <= cfg_data[0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    assign hdr_in.packet_size  = packet_size;
    assign hdr_in.version_word = version_word;
    assign hdr_in.frame_number = frame_number;
    assign hdr_in.chunk_offset = chunk_offset;
    assign hdr_in.chunk_length = chunk_length;

    cfrc_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hdr_in    (hdr_in),
        .take      (take),
        .hdr_valid (hdr_valid),
        .hdr_out   (hdr)
    );

    // Header checks against the current expectations.
    cfrc_eval #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_eval (
        .hdr        (hdr),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .track_next (track_next),
        .result     (eval_result)
    );

    // A header moves on when the result register is empty or being drained.
    assign take = hdr_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        rejected_count_next = rejected_count_reg + 32'(eval_result.rejected);
        received_count_next = received_count_reg + 32'd1;
        out_valid_next      = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Tracking state, counters and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg          <= '0;
            rejected_count_reg <= '0;
            received_count_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                track_reg          <= track_next;
                rejected_count_reg <= rejected_count_next;
                received_count_reg <= received_count_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= eval_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign write_valid  = result_reg.write_valid;
    assign write_offset = result_reg.write_offset;
    assign write_length = result_reg.write_length;
    assign frame_done   = result_reg.frame_done;
    assign frame_bytes  = result_reg.frame_bytes;
    assign error_total  = rejected_count_reg;
    assign packet_total = received_count_reg;

    // A write window only comes with an accepted chunk.
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> status == ST_OK)
        else $error("write window with a non-ok status");

    // A completed frame only comes with an accepted chunk.
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> status == ST_OK)
        else $error("frame done with a non-ok status");

    // Every header that moves on is counted once.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> received_count_reg == $past(received_count_reg) + 32'd1)
        else $error("packet count did not advance by one");

    // Expectations change only when a header is checked.
    a_track_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(track_reg) && $stable(rejected_count_reg))
        else $error("tracking state changed without a header");

    // A result waiting under stall is not overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !take)
        else $error("result overwritten while stalled");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chunked_frame_reassembly_checker
// Feeds decoded datagram headers through the valid/stall input channel,
// predicts every result from a local model of the header checks and of the
// expected frame and offset, and compares each result field by field. A
// directed opening covers each status code, the payload and image limits and
// frame number wrap. Random frame streams with injected faults follow, run
// under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import cfrc_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int PHASES          = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;

    // Expected result of one header request.
    typedef struct packed {
        status_t     status;
        logic        write_valid;
        logic [18:0] write_offset;
        logic [15:0] write_length;
        logic        frame_done;
        logic [18:0] frame_bytes;
        logic [31:0] error_total;
        logic [31:0] packet_total;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] packet_size;
    logic [31:0] version_word;
    logic [31:0] frame_number;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic        write_valid;
    logic [18:0] write_offset;
    logic [15:0] write_length;
    logic        frame_done;
    logic [18:0] frame_bytes;
    logic [31:0] error_total;
    logic [31:0] packet_total;

    // Local copy of the configuration registers.
    logic [15:0] cfg_version;
    logic        cfg_frame_check;
    logic        cfg_offset_check;

    // Frame tracking as the block sees it, and as the stimulus generator
    // expects it once every queued header has gone through.
    track_t      dut_track;
    track_t      gen_track;
    logic [31:0] rejected_total;
    logic [31:0] received_total;

    header_t     header_backlog[$];
    verdict_t    pending_verdicts[$];

    bit          in_fire;
    bit          send_quiet;
    bit          recv_quiet;
    int          send_gap;
    int          stall_left;
    int          cycle_count;
    int          mismatch_count;
    int          status_seen [8];
    int          settings_run;

    chunked_frame_reassembly_checker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packet_size  (packet_size),
        .version_word (version_word),
        .frame_number (frame_number),
        .chunk_offset (chunk_offset),
        .chunk_length (chunk_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .write_valid  (write_valid),
        .write_offset (write_offset),
        .write_length (write_length),
        .frame_done   (frame_done),
        .frame_bytes  (frame_bytes),
        .error_total  (error_total),
        .packet_total (packet_total)
    );

    always #2 clk = ~clk;

    // Checks one header against the configuration and advances the tracking.
    task automatic judge_header(input header_t h, inout track_t trk, output verdict_t v);
        logic [32:0] span;
        logic [15:0] payload;
        logic        last;
        v        = '0;
        v.status = ST_OK;
        span     = {1'b0, h.chunk_offset} + {1'b0, h.chunk_length};
        payload  = h.packet_size - HEADER_BYTES;
        last     = h.version_word[LAST_BIT];
        if (h.packet_size < VERSION_BYTES)
            v.status = ST_SHORT;
        else if (h.version_word[15:0] != cfg_version)
            v.status = ST_VERSION;
        else if (h.packet_size == VERSION_BYTES)
            v.status = ST_HEADER;
        else if (h.packet_size < HEADER_BYTES || 32'(payload) > MAX_PAYLOAD_DEF ||
                 h.chunk_length != 32'(payload))
            v.status = ST_LENGTH;
        else if (cfg_frame_check && trk.next_frame < h.frame_number)
        begin
            v.status        = ST_FRAME;
            trk.next_frame  = h.frame_number + 32'd1;
            trk.next_offset = '0;
        end
        else if (cfg_offset_check && trk.next_offset != h.chunk_offset)
        begin
            v.status        = ST_OFFSET;
            trk.next_frame  = h.frame_number + 32'd1;
            trk.next_offset = '0;
        end
        else
        begin
            // Accepted chunk: tracking moves on even when it overruns the image.
            if (last)
            begin
                trk.next_frame  = trk.next_frame + 32'd1;
                trk.next_offset = '0;
            end
            else
                trk.next_offset = trk.next_offset + h.chunk_length;
            if (span > 33'(IMAGE_BYTES_DEF))
                v.status = ST_BEYOND;
            else
            begin
                if (h.chunk_length != '0)
                begin
                    v.write_valid  = 1'b1;
                    v.write_offset = h.chunk_offset[18:0];
                    v.write_length = h.chunk_length[15:0];
                end
                if (last)
                begin
                    v.frame_done  = 1'b1;
                    v.frame_bytes = span[18:0];
                end
            end
        end
    endtask

    // Queues a header and follows its effect on the expected tracking.
    task automatic queue_header(input header_t h);
        verdict_t ignored;
        judge_header(h, gen_track, ignored);
        header_backlog.push_back(h);
    endtask

    // Well-formed chunk header; the spare version bits carry random noise.
    function automatic header_t chunk(input logic last, input logic [31:0] frame,
                                      input logic [31:0] offs, input logic [31:0] len);
        header_t h;
        h.packet_size  = 16'(len + 32'd16);
        h.version_word = {15'($urandom), last, cfg_version};
        h.frame_number = frame;
        h.chunk_offset = offs;
        h.chunk_length = len;
        return h;
    endfunction

    // Gap length for either channel: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Chunk payload length: mostly small, some up to the payload limit.
    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 85)
            return $urandom_range(1, 1500);
        else
            return $urandom_range(1500, MAX_PAYLOAD_DEF);
    endfunction

    // Next random header: mostly the next chunk of the current frame, the
    // rest damaged in one way or another.
    function automatic header_t random_header();
        header_t h;
        int      pick;
        pick = $urandom_range(0, 99);
        h = chunk($urandom_range(0, 3) == 0, gen_track.next_frame,
                  gen_track.next_offset, pick_length());
        if (pick < 7)
            h.frame_number = h.frame_number - 32'($urandom_range(1, 5));
        else if (pick < 70)
            ;
        else if (pick < 74)
        begin
            h.packet_size  = 16'($urandom_range(0, 3));
            h.frame_number = $urandom;
            h.chunk_offset = $urandom;
            h.chunk_length = $urandom;
        end
        else if (pick < 77)
            h.packet_size = VERSION_BYTES;
        else if (pick < 81)
            h.version_word[15:0] = cfg_version ^ 16'($urandom_range(1, 65535));
        else if (pick < 86)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                h.packet_size  = 16'($urandom_range(5, 65535));
                h.chunk_length = $urandom;
            end
            else
                h.chunk_length = h.chunk_length + 32'd1;
        end
        else if (pick < 91)
        begin
            if ($urandom_range(0, 1) == 1)
                h.frame_number = gen_track.next_frame + 32'($urandom_range(1, 1000));
            else
                h.frame_number = $urandom;
        end
        else if (pick < 96)
        begin
            if ($urandom_range(0, 1) == 1)
                h.chunk_offset = h.chunk_offset ^ 32'($urandom_range(1, 65535));
            else
                h.chunk_offset = $urandom;
        end
        else
        begin
            h.packet_size  = 16'($urandom);
            h.version_word = $urandom;
            h.frame_number = $urandom;
            h.chunk_offset = $urandom;
            h.chunk_length = $urandom;
            if ($urandom_range(0, 1) == 1)
                h.version_word[15:0] = cfg_version;
        end
        return h;
    endfunction

    // Register write while the block is idle; the local copy follows.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_EXPECTED_VERSION: cfg_version      = value;
            CFG_FRAME_CHECK:      cfg_frame_check  = value[0];
            CFG_OFFSET_CHECK:     cfg_offset_check = value[0];
            default: ;
        endcase
    endtask

    // Waits until every queued request has been taken and every result seen.
    task automatic wait_drained();
        while (header_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Request driver: holds a header until taken, then idles or sends the next.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (header_backlog.size() != 0)
        begin : send_next
            header_t h;
            h = header_backlog.pop_front();
            packet_size  <= h.packet_size;
            version_word <= h.version_word;
            frame_number <= h.frame_number;
            chunk_offset <= h.chunk_offset;
            chunk_length <= h.chunk_length;
            in_valid     <= 1'b1;
            send_gap     <= send_quiet ? 0 : pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= recv_quiet ? 0 : pick_gap();
        end
    end

    // Monitor: compares each result taken, then predicts each request taken.
    always @(posedge clk)
    begin : monitor
        header_t  h;
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with no request outstanding, status %0d",
                         $time, status);
                mismatch_count++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                check_field("status",       v.status,       status);
                check_field("write_valid",  v.write_valid,  write_valid);
                check_field("write_offset", v.write_offset, write_offset);
                check_field("write_length", v.write_length, write_length);
                check_field("frame_done",   v.frame_done,   frame_done);
                check_field("frame_bytes",  v.frame_bytes,  frame_bytes);
                check_field("error_total",  v.error_total,  error_total);
                check_field("packet_total", v.packet_total, packet_total);
            end
        end
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            h = {packet_size, version_word, frame_number, chunk_offset, chunk_length};
            judge_header(h, dut_track, v);
            if (v.status >= ST_SHORT && v.status <= ST_OFFSET)
                rejected_total = rejected_total + 32'd1;
            received_total = received_total + 32'd1;
            v.error_total  = rejected_total;
            v.packet_total = received_total;
            status_seen[v.status]++;
            pending_verdicts.push_back(v);
        end
    end

    // Run limit, and random stretches with no idling on either side.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ($urandom_range(0, 149) == 0)
            send_quiet <= !send_quiet;
        if ($urandom_range(0, 149) == 0)
            recv_quiet <= !recv_quiet;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] version_plan [PHASES];
        logic [15:0] frame_plan   [PHASES];
        logic [15:0] offset_plan  [PHASES];
        version_plan = '{16'hFFFF, 16'h0000, 16'h0000, VERSION_RESET};
        frame_plan   = '{16'h0001, 16'hFFFE, 16'h0001, 16'h0000};
        offset_plan  = '{16'h0001, 16'h0001, 16'h0000, 16'h0000};
        version_plan[2] = 16'($urandom);

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_EXPECTED_VERSION;
        cfg_data     = '0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        packet_size  = '0;
        version_word = '0;
        frame_number = '0;
        chunk_offset = '0;
        chunk_length = '0;
        cfg_version      = VERSION_RESET;
        cfg_frame_check  = 1'b1;
        cfg_offset_check = 1'b1;
        dut_track        = '0;
        gen_track        = '0;
        rejected_total   = '0;
        received_total   = '0;
        settings_run     = 1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening under the reset configuration.
        queue_header({16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        queue_header({16'd3, 16'h0000, VERSION_RESET, 32'd0, 32'd0, 32'd0});
        queue_header({16'd4, 16'h0001, VERSION_RESET, 32'd0, 32'd0, 32'd0});
        queue_header({16'd4, 16'h0000, ~VERSION_RESET, 32'd0, 32'd0, 32'd0});
        queue_header({16'd10, 16'h0000, VERSION_RESET, 32'd0, 32'd0, 32'hFFFF_FFFA});
        // Empty chunk, then a normal one.
        queue_header(chunk(1'b0, 32'd0, 32'd0, 32'd0));
        queue_header(chunk(1'b0, 32'd0, 32'd0, 32'd100));
        // Declared length wrong, payloads above the limit, then one at the limit.
        queue_header({16'd116, 16'h0000, VERSION_RESET, 32'd0, 32'd100, 32'd99});
        queue_header({16'hFFFF, 16'h0000, VERSION_RESET, 32'd0, 32'd100, 32'd65519});
        queue_header({16'd61457, 16'h0000, VERSION_RESET, 32'd0, 32'd100, 32'd61441});
        queue_header(chunk(1'b0, 32'd0, 32'd100, MAX_PAYLOAD_DEF));
        // Offset out of order, frame ahead, then a last chunk of an older frame.
        queue_header(chunk(1'b0, 32'd0, 32'd5, 32'd10));
        queue_header(chunk(1'b0, 32'd9, 32'd0, 32'd10));
        queue_header(chunk(1'b1, 32'd3, 32'd0, 32'd200));
        // A frame that fills the image exactly, then one that overruns it.
        for (int k = 0; k < 4; k++)
            queue_header(chunk(1'b0, 32'd11, 32'(k * 61440), 32'd61440));
        queue_header(chunk(1'b1, 32'd11, 32'd245760, 32'd16384));
        for (int k = 0; k < 4; k++)
            queue_header(chunk(1'b0, 32'd12, 32'(k * 61440), 32'd61440));
        queue_header(chunk(1'b1, 32'd12, 32'd245760, 32'd16385));
        // Frame number wraps after the top frame.
        queue_header(chunk(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd1));
        queue_header(chunk(1'b1, 32'd0, 32'd0, 32'd1));
        wait_drained();

        // Random frame streams under each register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_EXPECTED_VERSION, version_plan[p]);
            write_reg(CFG_FRAME_CHECK, frame_plan[p]);
            write_reg(CFG_OFFSET_CHECK, offset_plan[p]);
            settings_run++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_header(random_header());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d headers under %0d register settings: ok %0d, header only %0d,",
                 received_total, settings_run, status_seen[ST_OK], status_seen[ST_HEADER]);
        $display("short %0d, version %0d, length %0d, frame %0d, offset %0d, beyond %0d",
                 status_seen[ST_SHORT], status_seen[ST_VERSION], status_seen[ST_LENGTH],
                 status_seen[ST_FRAME], status_seen[ST_OFFSET], status_seen[ST_BEYOND]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
